[hw/rtl/fcs_pkg.sv]
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and codes of the flash command sequencer: request and issue
// codes, driver state, operation kind and the word layouts.
// ----------------------------------------------------------------------------
package fcs_pkg;

	localparam int REQ_W  = 4;
	localparam int ADDR_W = 24;
	localparam int LEN_W  = 25;

	// request and completion event codes
	typedef enum logic [REQ_W-1:0] {
		REQ_READ      = 4'd0,
		REQ_WRITE     = 4'd1,
		REQ_SEC_ERASE = 4'd2,
		REQ_BLK_ERASE = 4'd3,
		REQ_MAP_ON    = 4'd4,
		REQ_MAP_OFF   = 4'd5,
		REQ_RX_DONE   = 4'd6,
		REQ_TX_DONE   = 4'd7,
		REQ_BUSY_CLR  = 4'd8,
		REQ_ERROR     = 4'd9
	} req_code_t;

	typedef enum logic [1:0] {
		ACC_OK    = 2'd0,
		ACC_BUSY  = 2'd1,
		ACC_ERROR = 2'd2
	} acc_status_t;

	typedef enum logic [1:0] {
		DRV_IDLE  = 2'd0,
		DRV_BUSY  = 2'd1,
		DRV_ERROR = 2'd2
	} drv_state_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_ERASE = 2'd3
	} op_kind_t;

	typedef enum logic [2:0] {
		ISS_NONE   = 3'd0,
		ISS_READ   = 3'd1,
		ISS_PROG   = 3'd2,
		ISS_SERASE = 3'd3,
		ISS_BERASE = 3'd4,
		ISS_POLL   = 3'd5,
		ISS_MAP    = 3'd6,
		ISS_ABORT  = 3'd7
	} issue_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  length;
		logic              launch_ok;
	} fcs_req_t;

	typedef struct packed {
		acc_status_t       accept_status;
		drv_state_t        driver_state;
		logic              mapped;
		issue_t            issue;
		logic [ADDR_W-1:0] cmd_address;
		logic [LEN_W-1:0]  cmd_length;
	} fcs_rsp_t;

	// driver control state shared between the top level and the step logic
	typedef struct packed {
		drv_state_t drv_state;
		op_kind_t   active_op;
		logic       map_flag;
	} fcs_ctl_t;

endpackage

[hw/rtl/fcs_req_if.sv]
// ----------------------------------------------------------------------------
// fcs_req_if
// Request channel: valid/ready handshake carrying one request or event word.
// ----------------------------------------------------------------------------
interface fcs_req_if;
	logic                       valid;
	logic                       ready;
	logic [fcs_pkg::REQ_W-1:0]  req_type;
	logic [fcs_pkg::ADDR_W-1:0] address;
	logic [fcs_pkg::LEN_W-1:0]  length;
	logic                       launch_ok;

	modport source (output valid, req_type, address, length, launch_ok, input ready);
	modport sink (input valid, req_type, address, length, launch_ok, output ready);
endinterface

[hw/rtl/fcs_rsp_if.sv]
// ----------------------------------------------------------------------------
// fcs_rsp_if
// Result channel: valid/ready handshake carrying one status and command word.
// ----------------------------------------------------------------------------
interface fcs_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 accept_status;
	logic [1:0]                 driver_state;
	logic                       mapped;
	logic [2:0]                 issue;
	logic [fcs_pkg::ADDR_W-1:0] cmd_address;
	logic [fcs_pkg::LEN_W-1:0]  cmd_length;

	modport source (output valid, accept_status, driver_state, mapped, issue,
		cmd_address, cmd_length, input ready);
	modport sink (input valid, accept_status, driver_state, mapped, issue,
		cmd_address, cmd_length, output ready);
endinterface

[hw/rtl/flash_command_sequencer_core.sv]
// ----------------------------------------------------------------------------
// flash_command_sequencer_core
// Command sequencer for a serial NOR flash: checks requests and completion
// events and issues the matching flash command, page by page for writes.
// ----------------------------------------------------------------------------
// Each word on req is a request (read, write, sector or block erase, map on,
// map off) or a completion event (rx done, tx done, busy cleared, error), and
// each one gives exactly one word on rsp with the accept status, the driver
// state after the word, the mapped flag and the command issued to the flash
// peripheral. A word is taken into an input register, the step logic works
// it out and loads the result register while updating the driver state, so
// the block takes one word per clock while rsp is not stalled, and a result
// is valid on rsp once its word has passed the input and result registers.
// The rate is set by the loop from the driver state registers through the
// step logic back to themselves.
// While a result waits on rsp the input register still takes one more word;
// req.ready drops only when both registers are full and rsp is stalled.
// Writes are split at PAGE_BYTES boundaries, which must be a power of two;
// a busy-cleared event during a write moves the write cursor to the next
// page. Address arithmetic wraps at ADDR_BITS bits.
// ----------------------------------------------------------------------------
module flash_command_sequencer_core #(
	parameter int PAGE_BYTES = 256,
	parameter int ADDR_BITS  = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	fcs_req_if.sink   req,
	fcs_rsp_if.source rsp
);
	import fcs_pkg::*;

	localparam int CHUNK_W = $clog2(PAGE_BYTES) + 1;

	// input register
	logic     v_s1;
	fcs_req_t req_s1;

	// result register
	logic     rsp_valid_q;
	fcs_rsp_t rsp_q;

	// driver state
	fcs_ctl_t             ctl_q;
	logic [ADDR_BITS-1:0] cursor_q;
	logic [LEN_W-1:0]     left_q;
	logic [CHUNK_W-1:0]   chunk_q;

	// step outputs
	fcs_ctl_t             ctl_nxt;
	logic [ADDR_BITS-1:0] cursor_nxt;
	logic [LEN_W-1:0]     left_nxt;
	logic [CHUNK_W-1:0]   chunk_nxt;
	fcs_rsp_t             rsp_nxt;

	logic s1_adv;
	logic in_take;

	// the word in s1 moves on when the result register is free or drains now
	assign s1_adv    = v_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !v_s1 || s1_adv;
	assign in_take   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (in_take)
				v_s1 <= 1'b1;
			else if (s1_adv)
				v_s1 <= 1'b0;

			if (s1_adv)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1.req_type  <= req.req_type;
			req_s1.address   <= req.address;
			req_s1.length    <= req.length;
			req_s1.launch_ok <= req.launch_ok;
		end
		if (s1_adv)
			rsp_q <= rsp_nxt;
	end

	// driver state follows each word as it leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.drv_state <= DRV_IDLE;
			ctl_q.active_op <= OP_NONE;
			ctl_q.map_flag  <= 1'b0;
			cursor_q        <= '0;
			left_q          <= '0;
			chunk_q         <= '0;
		end else if (s1_adv) begin
			ctl_q    <= ctl_nxt;
			cursor_q <= cursor_nxt;
			left_q   <= left_nxt;
			chunk_q  <= chunk_nxt;
		end
	end

	fcs_step #(
		.PAGE_BYTES (PAGE_BYTES),
		.ADDR_BITS  (ADDR_BITS),
		.CHUNK_W    (CHUNK_W)
	) u_step (
		.req        (req_s1),
		.ctl        (ctl_q),
		.cursor     (cursor_q),
		.left       (left_q),
		.chunk      (chunk_q),
		.ctl_nxt    (ctl_nxt),
		.cursor_nxt (cursor_nxt),
		.left_nxt   (left_nxt),
		.chunk_nxt  (chunk_nxt),
		.rsp        (rsp_nxt)
	);

	assign rsp.valid         = rsp_valid_q;
	assign rsp.accept_status = rsp_q.accept_status;
	assign rsp.driver_state  = rsp_q.driver_state;
	assign rsp.mapped        = rsp_q.mapped;
	assign rsp.issue         = rsp_q.issue;
	assign rsp.cmd_address   = rsp_q.cmd_address;
	assign rsp.cmd_length    = rsp_q.cmd_length;

	// a busy refusal leaves the driver state untouched
	a_refuse_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && rsp_nxt.accept_status == ACC_BUSY |=> $stable(ctl_q) && $stable(cursor_q))
		else $error("busy refusal changed driver state");

	// memory-mapped mode and a running operation never coexist
	a_map_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl_q.map_flag && ctl_q.drv_state == DRV_BUSY))
		else $error("mapped while busy");

	// a page chunk never crosses a page
	a_chunk_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_q <= CHUNK_W'(PAGE_BYTES))
		else $error("page chunk larger than a page");

	// input stalls only when both registers hold a word
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> v_s1 && rsp_valid_q && !rsp.ready)
		else $error("input stalled with room left");

endmodule

[hw/rtl/fcs_step.sv]
// ----------------------------------------------------------------------------
// fcs_step
// Next-state and result logic for one word: request checks, command issue
// and page splitting of writes.
// ----------------------------------------------------------------------------
module fcs_step #(
	parameter int PAGE_BYTES = 256,
	parameter int ADDR_BITS  = 24,
	parameter int CHUNK_W    = $clog2(PAGE_BYTES) + 1
) (
	input  fcs_pkg::fcs_req_t         req,
	input  fcs_pkg::fcs_ctl_t         ctl,
	input  logic [ADDR_BITS-1:0]      cursor,
	input  logic [fcs_pkg::LEN_W-1:0] left,
	input  logic [CHUNK_W-1:0]        chunk,
	output fcs_pkg::fcs_ctl_t         ctl_nxt,
	output logic [ADDR_BITS-1:0]      cursor_nxt,
	output logic [fcs_pkg::LEN_W-1:0] left_nxt,
	output logic [CHUNK_W-1:0]        chunk_nxt,
	output fcs_pkg::fcs_rsp_t         rsp
);
	import fcs_pkg::*;

	localparam int PAGE_LOG = $clog2(PAGE_BYTES);

	// bytes up to the end of the page, capped by what is left
	function automatic logic [CHUNK_W-1:0] chunk_for(input logic [ADDR_BITS-1:0] cur,
		input logic [LEN_W-1:0] rem);
		logic [CHUNK_W-1:0] room;
		room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(cur[PAGE_LOG-1:0]);
		chunk_for = (rem < LEN_W'(room)) ? rem[CHUNK_W-1:0] : room;
	endfunction

	logic [ADDR_BITS-1:0] req_addr;
	logic [CHUNK_W-1:0]   wr_chunk;
	logic [ADDR_BITS-1:0] adv_cursor;
	logic [LEN_W-1:0]     adv_left;
	logic [CHUNK_W-1:0]   adv_chunk;
	logic                 indirect;

	assign req_addr   = ADDR_BITS'(req.address);
	assign wr_chunk   = chunk_for(req_addr, req.length);
	assign adv_cursor = cursor + ADDR_BITS'(chunk);
	assign adv_left   = (left >= LEN_W'(chunk)) ? (left - LEN_W'(chunk)) : '0;
	assign adv_chunk  = chunk_for(adv_cursor, adv_left);
	assign indirect   = req.req_type inside {REQ_READ, REQ_WRITE, REQ_SEC_ERASE, REQ_BLK_ERASE};

	always_comb begin
		ctl_nxt    = ctl;
		cursor_nxt = cursor;
		left_nxt   = left;
		chunk_nxt  = chunk;
		rsp.accept_status = ACC_OK;
		rsp.issue         = ISS_NONE;
		rsp.cmd_address   = '0;
		rsp.cmd_length    = '0;

		if (indirect && ctl.map_flag) begin
			rsp.accept_status = ACC_ERROR;
		end else if ((indirect || req.req_type == REQ_MAP_ON) && ctl.drv_state == DRV_BUSY) begin
			rsp.accept_status = ACC_BUSY;
		end else begin
			case (req.req_type)
				REQ_READ: begin
					rsp.issue       = ISS_READ;
					rsp.cmd_address = ADDR_W'(req_addr);
					rsp.cmd_length  = req.length;
					ctl_nxt.active_op = OP_READ;
					ctl_nxt.drv_state = DRV_BUSY;
				end
				REQ_WRITE: begin
					cursor_nxt = req_addr;
					left_nxt   = req.length;
					chunk_nxt  = wr_chunk;
					rsp.issue       = ISS_PROG;
					rsp.cmd_address = ADDR_W'(req_addr);
					rsp.cmd_length  = LEN_W'(wr_chunk);
					ctl_nxt.active_op = OP_WRITE;
					ctl_nxt.drv_state = DRV_BUSY;
				end
				REQ_SEC_ERASE, REQ_BLK_ERASE: begin
					rsp.issue = (req.req_type == REQ_SEC_ERASE) ? ISS_SERASE : ISS_BERASE;
					rsp.cmd_address = ADDR_W'(req_addr);
					ctl_nxt.active_op = OP_ERASE;
					ctl_nxt.drv_state = DRV_BUSY;
				end
				REQ_MAP_ON: begin
					if (!ctl.map_flag) begin
						rsp.issue = ISS_MAP;
						if (req.launch_ok)
							ctl_nxt.map_flag = 1'b1;
						else
							rsp.accept_status = ACC_ERROR;
					end
				end
				REQ_MAP_OFF: begin
					if (ctl.map_flag) begin
						rsp.issue = ISS_ABORT;
						if (req.launch_ok) begin
							ctl_nxt.map_flag  = 1'b0;
							ctl_nxt.active_op = OP_NONE;
							ctl_nxt.drv_state = DRV_IDLE;
						end else begin
							rsp.accept_status = ACC_ERROR;
						end
					end
				end
				REQ_RX_DONE: begin
					ctl_nxt.active_op = OP_NONE;
					ctl_nxt.drv_state = DRV_IDLE;
				end
				REQ_TX_DONE: begin
					rsp.issue = ISS_POLL;
				end
				REQ_BUSY_CLR: begin
					ctl_nxt.active_op = OP_NONE;
					ctl_nxt.drv_state = DRV_IDLE;
					if (ctl.active_op == OP_WRITE) begin
						cursor_nxt = adv_cursor;
						left_nxt   = adv_left;
						if (adv_left != '0) begin
							// next page of the write
							chunk_nxt = adv_chunk;
							rsp.issue       = ISS_PROG;
							rsp.cmd_address = ADDR_W'(adv_cursor);
							rsp.cmd_length  = LEN_W'(adv_chunk);
							ctl_nxt.active_op = OP_WRITE;
							ctl_nxt.drv_state = DRV_BUSY;
						end
					end
				end
				REQ_ERROR: begin
					ctl_nxt.active_op = OP_NONE;
					ctl_nxt.drv_state = DRV_ERROR;
				end
				default: begin
				end
			endcase

			// a launched command that the peripheral refused latches the error
			if (rsp.issue != ISS_NONE && rsp.issue != ISS_MAP && rsp.issue != ISS_ABORT &&
				!req.launch_ok) begin
				ctl_nxt.active_op = OP_NONE;
				ctl_nxt.drv_state = DRV_ERROR;
				rsp.accept_status = ACC_ERROR;
			end
		end

		rsp.driver_state = ctl_nxt.drv_state;
		rsp.mapped       = ctl_nxt.map_flag;
	end

endmodule

[bench/flash_command_sequencer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_command_sequencer_core_test
// Self-checking bench for the flash command sequencer. Request and event
// words go in on req, and every result word on rsp is compared field by
// field with the output of a cycle-free model of the driver kept here.
// ----------------------------------------------------------------------------
module flash_command_sequencer_core_test;
	import fcs_pkg::*;

	localparam int PAGE    = 256;
	localparam int ABITS   = 24;
	localparam int CHUNK_W = $clog2(PAGE) + 1;
	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ABITS) - 1);
	localparam logic [LEN_W-1:0] LEN_MAX = 25'h1000000;

	logic clk;
	logic arst_n;

	fcs_req_if req_ch();
	fcs_rsp_if rsp_ch();

	flash_command_sequencer_core #(
		.PAGE_BYTES(PAGE),
		.ADDR_BITS (ABITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// driver state as the bench predicts it
	drv_state_t         flash_state;
	op_kind_t           flash_op;
	logic               flash_mapped;
	logic [ADDR_W-1:0]  wr_cursor;
	logic [LEN_W-1:0]   wr_remaining;
	logic [CHUNK_W-1:0] wr_chunk;

	// predicted result words, oldest first
	fcs_rsp_t pending_rsp[$];

	// idling and stall control, shared by the driving processes
	int send_idle_pct = 16;
	int recv_idle_pct = 70;
	int stall_left    = 0;

	int words_sent    = 0;
	int results_seen  = 0;
	int pages_seen    = 0;
	int refusals_seen = 0;
	int failures      = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous ceiling on the run time
	initial begin
		#5_000_000;
		$display("** flash_command_sequencer_core: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// operation ends, either back to idle or latched in error
	function automatic void finish_op(bit failed);
		flash_op    = OP_NONE;
		flash_state = failed ? DRV_ERROR : DRV_IDLE;
	endfunction

	// a command goes out; a failed launch latches the error state at once
	function automatic acc_status_t begin_op(op_kind_t kind, logic ok);
		flash_op    = kind;
		flash_state = DRV_BUSY;
		if (!ok) begin
			finish_op(1'b1);
			return ACC_ERROR;
		end
		return ACC_OK;
	endfunction

	// bytes that fit from the cursor up to the next page boundary
	function automatic void next_chunk();
		logic [LEN_W-1:0] room;
		room     = LEN_W'(PAGE) - LEN_W'(wr_cursor % PAGE);
		wr_chunk = CHUNK_W'((wr_remaining < room) ? wr_remaining : room);
	endfunction

	function automatic fcs_rsp_t sequencer_step(fcs_req_t w);
		fcs_rsp_t          r;
		logic [ADDR_W-1:0] a;
		bit                more;
		r    = '0;
		more = 1'b0;
		a    = ADDR_W'(32'(w.address) & ADDR_MASK);
		// indirect access is refused while mapped, then anything up to map on while busy
		if (w.req_type <= REQ_BLK_ERASE && flash_mapped) begin
			r.accept_status = ACC_ERROR;
		end else if (w.req_type <= REQ_MAP_ON && flash_state == DRV_BUSY) begin
			r.accept_status = ACC_BUSY;
		end else begin
			case (w.req_type)
			REQ_READ: begin
				r.issue         = ISS_READ;
				r.cmd_address   = a;
				r.cmd_length    = w.length;
				r.accept_status = begin_op(OP_READ, w.launch_ok);
			end
			REQ_WRITE: begin
				wr_cursor    = a;
				wr_remaining = w.length;
				next_chunk();
				r.issue         = ISS_PROG;
				r.cmd_address   = wr_cursor;
				r.cmd_length    = LEN_W'(wr_chunk);
				r.accept_status = begin_op(OP_WRITE, w.launch_ok);
			end
			REQ_SEC_ERASE, REQ_BLK_ERASE: begin
				r.issue         = (w.req_type == REQ_SEC_ERASE) ? ISS_SERASE : ISS_BERASE;
				r.cmd_address   = a;
				r.accept_status = begin_op(OP_ERASE, w.launch_ok);
			end
			REQ_MAP_ON: if (!flash_mapped) begin
				r.issue = ISS_MAP;
				if (w.launch_ok)
					flash_mapped = 1'b1;
				else
					r.accept_status = ACC_ERROR;
			end
			REQ_MAP_OFF: if (flash_mapped) begin
				r.issue = ISS_ABORT;
				if (w.launch_ok) begin
					flash_mapped = 1'b0;
					finish_op(1'b0);
				end else begin
					r.accept_status = ACC_ERROR;
				end
			end
			REQ_RX_DONE: finish_op(1'b0);
			REQ_TX_DONE: begin
				r.issue = ISS_POLL;
				if (!w.launch_ok) begin
					finish_op(1'b1);
					r.accept_status = ACC_ERROR;
				end
			end
			REQ_BUSY_CLR: begin
				// a write in flight steps to the next page until no bytes are left
				if (flash_op == OP_WRITE) begin
					wr_cursor    = ADDR_W'((32'(wr_cursor) + 32'(wr_chunk)) & ADDR_MASK);
					wr_remaining = (wr_remaining >= wr_chunk) ? wr_remaining - wr_chunk : '0;
					if (wr_remaining != 0) begin
						more = 1'b1;
						next_chunk();
						r.issue         = ISS_PROG;
						r.cmd_address   = wr_cursor;
						r.cmd_length    = LEN_W'(wr_chunk);
						r.accept_status = begin_op(OP_WRITE, w.launch_ok);
					end
				end
				if (!more)
					finish_op(1'b0);
			end
			REQ_ERROR: finish_op(1'b1);
			default: ;
			endcase
		end
		r.driver_state = flash_state;
		r.mapped       = flash_mapped;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// driving and checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(string what);
		failures++;
		// keep the log short on a badly broken build
		if (failures <= 100)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// offer one word after a random gap and predict its result once taken
	task automatic send_word(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] addr,
		input logic [LEN_W-1:0] len, input logic ok);
		fcs_req_t w;
		w = '{kind, addr, len, ok};
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
		end
		@(negedge clk);
		req_ch.valid     = 1'b1;
		req_ch.req_type  = kind;
		req_ch.address   = addr;
		req_ch.length    = len;
		req_ch.launch_ok = ok;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsp.push_back(sequencer_step(w));
		words_sent++;
	endtask

	// stop offering and wait until every predicted word has come back
	task automatic drain_results();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	// receiver: a long stall when asked, random holds otherwise
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		fcs_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = pending_rsp.pop_front();
				results_seen++;
				if (want.issue == ISS_PROG)
					pages_seen++;
				if (want.accept_status != ACC_OK)
					refusals_seen++;
				if (rsp_ch.accept_status !== want.accept_status)
					report_mismatch($sformatf("word %0d accept_status %0d, expected %0d",
						results_seen, rsp_ch.accept_status, want.accept_status));
				if (rsp_ch.driver_state !== want.driver_state)
					report_mismatch($sformatf("word %0d driver_state %0d, expected %0d",
						results_seen, rsp_ch.driver_state, want.driver_state));
				if (rsp_ch.mapped !== want.mapped)
					report_mismatch($sformatf("word %0d mapped %0d, expected %0d",
						results_seen, rsp_ch.mapped, want.mapped));
				if (rsp_ch.issue !== want.issue)
					report_mismatch($sformatf("word %0d issue %0d, expected %0d",
						results_seen, rsp_ch.issue, want.issue));
				if (rsp_ch.cmd_address !== want.cmd_address)
					report_mismatch($sformatf("word %0d cmd_address %h, expected %h",
						results_seen, rsp_ch.cmd_address, want.cmd_address));
				if (rsp_ch.cmd_length !== want.cmd_length)
					report_mismatch($sformatf("word %0d cmd_length %h, expected %h",
						results_seen, rsp_ch.cmd_length, want.cmd_length));
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// a read runs, requests up to map on are refused busy, rx done ends it
	task automatic test_read_refusals();
		send_word(REQ_READ, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_MAP_ON, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_WRITE, 24'h000100, 25'd16, 1'b1);
		send_word(REQ_RX_DONE, 24'h000000, 25'd0, 1'b1);
	endtask

	// page split across the top of the address space, zero bytes, full length
	task automatic test_page_split_writes();
		send_word(REQ_WRITE, 24'hFFFFF0, 25'd32, 1'b1);
		send_word(REQ_BUSY_CLR, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_BUSY_CLR, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_WRITE, 24'h123456, 25'd0, 1'b1);
		send_word(REQ_BUSY_CLR, 24'hFFFFFF, LEN_MAX, 1'b1);
		send_word(REQ_WRITE, 24'hABCDEF, LEN_MAX, 1'b1);
		// an error event abandons the long write
		send_word(REQ_ERROR, 24'h000000, 25'd0, 1'b1);
	endtask

	// both erases, busy poll, rx done ending an erase, unknown codes
	task automatic test_erase_events();
		send_word(REQ_SEC_ERASE, 24'hFFFFFF, 25'd0, 1'b1);
		send_word(REQ_TX_DONE, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_BUSY_CLR, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_BLK_ERASE, 24'h010000, 25'd0, 1'b1);
		send_word(REQ_RX_DONE, 24'h000000, 25'd0, 1'b1);
		send_word(4'hA, 24'h555555, 25'h0AAAAAA, 1'b1);
		send_word(4'hF, 24'hAAAAAA, 25'h1555555, 1'b0);
	endtask

	// launches that fail, and a new request taken straight from error
	task automatic test_launch_failures();
		send_word(REQ_WRITE, 24'h0000FF, 25'd300, 1'b0);
		send_word(REQ_READ, 24'hFFFFFF, LEN_MAX, 1'b0);
		send_word(REQ_TX_DONE, 24'h000000, 25'd0, 1'b0);
		send_word(REQ_BUSY_CLR, 24'h000000, 25'd0, 1'b1);
	endtask

	// map on and off, repeated and failing, indirect access refused while mapped
	task automatic test_map_mode();
		send_word(REQ_MAP_OFF, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_MAP_ON, 24'h000000, 25'd0, 1'b0);
		send_word(REQ_MAP_ON, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_MAP_ON, 24'h000000, 25'd0, 1'b1);
		send_word(REQ_WRITE, 24'h000200, 25'd8, 1'b1);
		send_word(REQ_MAP_OFF, 24'h000000, 25'd0, 1'b0);
		send_word(REQ_MAP_OFF, 24'h000000, 25'd0, 1'b1);
	endtask

	// hold rsp for a long stretch while a multi-page write keeps req busy
	task automatic test_backpressure();
		int saved_pct;
		drain_results();
		saved_pct     = send_idle_pct;
		send_idle_pct = 0;
		send_word(REQ_WRITE, 24'($urandom), 25'd4096, 1'b1);
		stall_left = 80;
		repeat (14)
			send_word(REQ_BUSY_CLR, 24'($urandom), 25'($urandom), 1'b1);
		// sender waits for every result before going on
		drain_results();
		send_idle_pct = saved_pct;
	endtask

	// mostly well-formed operations with random content, plus noise
	task automatic test_random_traffic(int s_pct, int r_pct, int count);
		int                target;
		int                pick;
		int                n;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		target        = words_sent + count;
		while (words_sent < target) begin
			pick = $urandom_range(99);
			addr = 24'($urandom);
			if (pick < 30) begin
				// write, often starting near a page boundary
				if ($urandom_range(1))
					addr[7:0] = 8'hF0 + 8'($urandom_range(15));
				case ($urandom_range(9))
				0: len = '0;
				8: len = 25'($urandom_range(257, 1024));
				9: len = 25'($urandom_range(0, LEN_MAX));
				default: len = 25'($urandom_range(1, 256));
				endcase
				send_word(REQ_WRITE, addr, len, $urandom_range(19) != 0);
				n = 0;
				while (flash_op == OP_WRITE && n < 6) begin
					if ($urandom_range(19) == 0)
						send_word(4'($urandom_range(REQ_MAP_ON)), 24'($urandom),
							25'($urandom), $urandom_range(1));
					send_word(REQ_BUSY_CLR, 24'($urandom), 25'($urandom),
						$urandom_range(24) != 0);
					n++;
				end
				// cut short a write that is still going
				if (flash_op == OP_WRITE)
					send_word($urandom_range(1) ? REQ_ERROR : REQ_RX_DONE, 24'($urandom),
						25'($urandom), $urandom_range(1));
			end else if (pick < 45) begin
				len = $urandom_range(1) ? 25'($urandom_range(0, LEN_MAX))
					: 25'($urandom_range(0, 4096));
				send_word(REQ_READ, addr, len, $urandom_range(19) != 0);
				if ($urandom_range(9) < 8)
					send_word(REQ_RX_DONE, 24'($urandom), 25'($urandom), 1'b1);
				else
					send_word(4'($urandom_range(REQ_TX_DONE, REQ_ERROR)), 24'($urandom),
						25'($urandom), $urandom_range(1));
			end else if (pick < 60) begin
				send_word($urandom_range(1) ? REQ_SEC_ERASE : REQ_BLK_ERASE, addr,
					25'($urandom), $urandom_range(19) != 0);
				repeat ($urandom_range(2))
					send_word(REQ_TX_DONE, 24'($urandom), 25'($urandom),
						$urandom_range(9) != 0);
				send_word(REQ_BUSY_CLR, 24'($urandom), 25'($urandom), 1'b1);
			end else if (pick < 70) begin
				send_word(REQ_MAP_ON, addr, 25'($urandom), $urandom_range(9) != 0);
				repeat ($urandom_range(3))
					send_word(4'($urandom_range(REQ_BLK_ERASE)), 24'($urandom),
						25'($urandom_range(0, LEN_MAX)), $urandom_range(1));
				send_word(REQ_MAP_OFF, 24'($urandom), 25'($urandom), $urandom_range(9) != 0);
				if (flash_mapped)
					send_word(REQ_MAP_OFF, 24'($urandom), 25'($urandom), 1'b1);
			end else begin
				// loose words of any kind, fields random with the length at most LEN_MAX
				repeat ($urandom_range(1, 3))
					send_word(4'($urandom_range(REQ_ERROR)), 24'($urandom),
						25'($urandom_range(0, LEN_MAX)), $urandom_range(1));
			end
		end
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		req_ch.valid     = 1'b0;
		req_ch.req_type  = '0;
		req_ch.address   = '0;
		req_ch.length    = '0;
		req_ch.launch_ok = 1'b0;
		arst_n           = 1'b0;
		flash_state      = DRV_IDLE;
		flash_op         = OP_NONE;
		flash_mapped     = 1'b0;
		wr_cursor        = '0;
		wr_remaining     = '0;
		wr_chunk         = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_read_refusals();
		test_page_split_writes();
		test_erase_events();
		test_launch_failures();
		test_map_mode();
		test_backpressure();
		test_random_traffic(16, 70, 400);
		test_random_traffic(70, 16, 400);
		test_random_traffic(0, 0, 400);

		drain_results();
		// room for a stray extra result to show up
		repeat (10) @(posedge clk);

		$display("covered %0d request/event words and %0d result words, %0d page programs,",
			words_sent, results_seen, pages_seen);
		$display("%0d refused or failed words, under skewed, reversed and no idling and a long stall",
			refusals_seen);
		if (failures == 0) begin
			$display("** flash_command_sequencer_core: PASSED **");
		end else begin
			$display("** flash_command_sequencer_core: FAILED **");
		end
		$finish;
	end

endmodule
